### sv/gbn_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes, command/status types and sequence helpers for the go-back-n sender
package gbn_pkg;

  localparam int SEQ_SPACE        = 8;
  localparam int SEQ_W            = $clog2(SEQ_SPACE);
  localparam int PAY_W            = 64;
  localparam int PAYLOAD_BITS_DEF = 64;
  localparam int WIN_W            = 3;
  localparam int MODE_W           = 2;
  localparam int EV_W             = 3;
  localparam int TCMD_W           = 2;

  localparam logic [WIN_W-1:0] WIN_RESET = 3'd4;

  // input modes
  localparam logic [MODE_W-1:0] MODE_SEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TMO  = 2'd2;

  // result events
  localparam logic [EV_W-1:0] EV_SENT    = 3'd0;
  localparam logic [EV_W-1:0] EV_REFUSED = 3'd1;
  localparam logic [EV_W-1:0] EV_ACK_OK  = 3'd2;
  localparam logic [EV_W-1:0] EV_ACK_IGN = 3'd3;
  localparam logic [EV_W-1:0] EV_RETX    = 3'd4;

  // retransmit timer commands
  localparam logic [TCMD_W-1:0] TMR_NONE    = 2'd0;
  localparam logic [TCMD_W-1:0] TMR_START   = 2'd1;
  localparam logic [TCMD_W-1:0] TMR_STOP    = 2'd2;
  localparam logic [TCMD_W-1:0] TMR_RESTART = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic accept;      // input word taken this cycle
    logic start_walk;  // timeout with packets outstanding: set up resend walk
    logic rd_en;       // read store at walk index
    logic emit_walk;   // load resent packet into output register
  } gbn_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;       // nothing outstanding
    logic full;        // window full
    logic walk_last;   // current walk entry is the final one
    logic out_free;    // output register can take a word this cycle
  } gbn_sts_t;

  function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
    seq_inc = (32'(s) == SEQ_SPACE - 1) ? '0 : s + SEQ_W'(1);
  endfunction

  // (a - b) mod SEQ_SPACE
  function automatic logic [SEQ_W-1:0] seq_dist(input logic [SEQ_W-1:0] a,
                                                input logic [SEQ_W-1:0] b);
    logic [SEQ_W:0] sum;
    sum = {1'b0, a} + (SEQ_W+1)'(SEQ_SPACE) - {1'b0, b};
    if (32'(sum) >= SEQ_SPACE) begin
      sum = sum - (SEQ_W+1)'(SEQ_SPACE);
    end
    seq_dist = SEQ_W'(sum);
  endfunction

endpackage

### sv/gbn_ifs.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for sender input words and result words
interface gbn_in_if;
  logic                         valid;
  logic                         ready;
  logic [gbn_pkg::MODE_W-1:0]   mode;
  logic [gbn_pkg::PAY_W-1:0]    payload;
  logic [gbn_pkg::SEQ_W-1:0]    ack_num;
  logic                         ack_checksum_ok;

  modport source (output valid, mode, payload, ack_num, ack_checksum_ok, input ready);
  modport sink   (input valid, mode, payload, ack_num, ack_checksum_ok, output ready);
endinterface

interface gbn_out_if;
  logic                         valid;
  logic                         ready;
  logic [gbn_pkg::EV_W-1:0]     event_res;
  logic [gbn_pkg::SEQ_W-1:0]    seq_num;
  logic [gbn_pkg::PAY_W-1:0]    packet_payload;
  logic                         packet_valid;
  logic [gbn_pkg::TCMD_W-1:0]   timer_cmd;
  logic                         window_full;
  logic                         last;

  modport source (output valid, event_res, seq_num, packet_payload, packet_valid,
                  timer_cmd, window_full, last, input ready);
  modport sink   (input valid, event_res, seq_num, packet_payload, packet_valid,
                  timer_cmd, window_full, last, output ready);
endinterface

### sv/gbn_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
module gbn_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/gbn_ctrl.sv
`timescale 1ns / 1ps
// sender controller: input handshake and timeout resend sequencing
module gbn_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [gbn_pkg::MODE_W-1:0] in_mode,
  output logic                       in_ready,
  input  gbn_pkg::gbn_sts_t          sts,
  output gbn_pkg::gbn_cmd_t          cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       accept;

  assign in_ready = (state_r == ST_IDLE) && sts.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.accept     = accept;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_mode == gbn_pkg::MODE_TMO && !sts.empty) begin
          cmd.start_walk = 1'b1;
          state_nxt      = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_walk = 1'b1;
          state_nxt     = sts.walk_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sv/gbn_dp.sv
`timescale 1ns / 1ps
// sender datapath: window registers, payload store, resend walk and output register
module gbn_dp #(
  parameter int PAYLOAD_BITS = gbn_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [gbn_pkg::WIN_W-1:0]  cfg_wdata,
  input  logic [gbn_pkg::MODE_W-1:0] in_mode,
  input  logic [gbn_pkg::PAY_W-1:0]  in_payload,
  input  logic [gbn_pkg::SEQ_W-1:0]  in_ack_num,
  input  logic                       in_ack_checksum_ok,
  input  logic                       out_ready,
  input  gbn_pkg::gbn_cmd_t          cmd,
  output gbn_pkg::gbn_sts_t          sts,
  output logic                       out_valid,
  output logic [gbn_pkg::EV_W-1:0]   out_event_res,
  output logic [gbn_pkg::SEQ_W-1:0]  out_seq_num,
  output logic [gbn_pkg::PAY_W-1:0]  out_packet_payload,
  output logic                       out_packet_valid,
  output logic [gbn_pkg::TCMD_W-1:0] out_timer_cmd,
  output logic                       out_window_full,
  output logic                       out_last
);

  localparam int SW = gbn_pkg::SEQ_W;
  localparam int PW = gbn_pkg::PAY_W;

  logic [gbn_pkg::WIN_W-1:0] ws_r, ws_nxt;
  logic [SW-1:0]             base_r, base_nxt;
  logic [SW-1:0]             next_r, next_nxt;
  logic [SW-1:0]             idx_r, idx_nxt;
  logic [SW-1:0]             cnt_r, cnt_nxt;
  logic                      first_r, first_nxt;
  logic                      out_valid_r, out_valid_nxt;

  logic [gbn_pkg::EV_W-1:0]   ev_r, ev_nxt;
  logic [SW-1:0]              seq_r, seq_nxt;
  logic [PW-1:0]              pay_r, pay_nxt;
  logic                       pv_r, pv_nxt;
  logic [gbn_pkg::TCMD_W-1:0] tcmd_r, tcmd_nxt;
  logic                       wf_r, wf_nxt;
  logic                       last_r, last_nxt;

  logic [SW-1:0]           eff;
  logic [SW-1:0]           outst;
  logic                    full;
  logic                    empty;
  logic [SW-1:0]           next_inc;
  logic [SW-1:0]           ack_d;
  logic [SW-1:0]           base_ack;
  logic                    ack_ok;
  logic [PAYLOAD_BITS-1:0] store_wdata;
  logic [PAYLOAD_BITS-1:0] store_rdata;
  logic                    store_we;

  logic                       d_load;
  logic [gbn_pkg::EV_W-1:0]   d_ev;
  logic [SW-1:0]              d_seq;
  logic [PW-1:0]              d_pay;
  logic                       d_pv;
  logic [gbn_pkg::TCMD_W-1:0] d_tcmd;
  logic                       d_full;

  // effective window: zero counts as one, capped below the sequence space
  always_comb begin
    if (ws_r == '0) begin
      eff = SW'(1);
    end else if (32'(ws_r) > gbn_pkg::SEQ_SPACE - 1) begin
      eff = SW'(gbn_pkg::SEQ_SPACE - 1);
    end else begin
      eff = SW'(ws_r);
    end
  end

  assign outst       = gbn_pkg::seq_dist(next_r, base_r);
  assign full        = outst >= eff;
  assign empty       = (outst == '0);
  assign next_inc    = gbn_pkg::seq_inc(next_r);
  assign ack_d       = gbn_pkg::seq_dist(in_ack_num, base_r);
  assign base_ack    = gbn_pkg::seq_inc(in_ack_num);
  assign ack_ok      = in_ack_checksum_ok && (32'(in_ack_num) < gbn_pkg::SEQ_SPACE) &&
                       (ack_d < outst);
  assign store_wdata = in_payload[PAYLOAD_BITS-1:0];
  assign store_we    = cmd.accept && (in_mode == gbn_pkg::MODE_SEND) && !full;

  gbn_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (gbn_pkg::SEQ_SPACE)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (next_r),
    .wdata (store_wdata),
    .re    (cmd.rd_en),
    .raddr (idx_r),
    .rdata (store_rdata)
  );

  // single-result outcome of the accepted word
  always_comb begin
    d_load = 1'b0;
    d_ev   = gbn_pkg::EV_SENT;
    d_seq  = '0;
    d_pay  = '0;
    d_pv   = 1'b0;
    d_tcmd = gbn_pkg::TMR_NONE;
    d_full = full;
    unique case (in_mode)
      gbn_pkg::MODE_SEND: begin
        d_load = 1'b1;
        if (full) begin
          d_ev = gbn_pkg::EV_REFUSED;
        end else begin
          d_seq  = next_r;
          d_pay  = PW'(store_wdata);
          d_pv   = 1'b1;
          d_tcmd = empty ? gbn_pkg::TMR_START : gbn_pkg::TMR_NONE;
          d_full = gbn_pkg::seq_dist(next_inc, base_r) >= eff;
        end
      end
      gbn_pkg::MODE_ACK: begin
        d_load = 1'b1;
        if (ack_ok) begin
          d_ev   = gbn_pkg::EV_ACK_OK;
          d_tcmd = (base_ack == next_r) ? gbn_pkg::TMR_STOP : gbn_pkg::TMR_RESTART;
          d_full = gbn_pkg::seq_dist(next_r, base_ack) >= eff;
        end else begin
          d_ev = gbn_pkg::EV_ACK_IGN;
        end
      end
      gbn_pkg::MODE_TMO: begin
        d_load = empty;
        d_ev   = gbn_pkg::EV_RETX;
        d_tcmd = gbn_pkg::TMR_RESTART;
      end
      default: begin
        d_load = 1'b0;
      end
    endcase
  end

  always_comb begin
    ws_nxt        = ws_r;
    base_nxt      = base_r;
    next_nxt      = next_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r;
    ev_nxt        = ev_r;
    seq_nxt       = seq_r;
    pay_nxt       = pay_r;
    pv_nxt        = pv_r;
    tcmd_nxt      = tcmd_r;
    wf_nxt        = wf_r;
    last_nxt      = last_r;

    if (cfg_we) begin
      ws_nxt = cfg_wdata;
    end
    if (store_we) begin
      next_nxt = next_inc;
    end
    if (cmd.accept && in_mode == gbn_pkg::MODE_ACK && ack_ok) begin
      base_nxt = base_ack;
    end

    if (cmd.start_walk) begin
      idx_nxt   = base_r;
      cnt_nxt   = outst;
      first_nxt = 1'b1;
    end else if (cmd.emit_walk) begin
      idx_nxt   = gbn_pkg::seq_inc(idx_r);
      cnt_nxt   = cnt_r - SW'(1);
      first_nxt = 1'b0;
    end

    priority if (cmd.accept && d_load) begin
      out_valid_nxt = 1'b1;
      ev_nxt        = d_ev;
      seq_nxt       = d_seq;
      pay_nxt       = d_pay;
      pv_nxt        = d_pv;
      tcmd_nxt      = d_tcmd;
      wf_nxt        = d_full;
      last_nxt      = 1'b1;
    end else if (cmd.emit_walk) begin
      out_valid_nxt = 1'b1;
      ev_nxt        = gbn_pkg::EV_RETX;
      seq_nxt       = idx_r;
      pay_nxt       = PW'(store_rdata);
      pv_nxt        = 1'b1;
      tcmd_nxt      = first_r ? gbn_pkg::TMR_RESTART : gbn_pkg::TMR_NONE;
      wf_nxt        = full;
      last_nxt      = (cnt_r == SW'(1));
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r        <= gbn_pkg::WIN_RESET;
      base_r      <= '0;
      next_r      <= '0;
      cnt_r       <= '0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ws_r        <= ws_nxt;
      base_r      <= base_nxt;
      next_r      <= next_nxt;
      cnt_r       <= cnt_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    ev_r   <= ev_nxt;
    seq_r  <= seq_nxt;
    pay_r  <= pay_nxt;
    pv_r   <= pv_nxt;
    tcmd_r <= tcmd_nxt;
    wf_r   <= wf_nxt;
    last_r <= last_nxt;
  end

  assign sts.empty     = empty;
  assign sts.full      = full;
  assign sts.walk_last = (cnt_r == SW'(1));
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid          = out_valid_r;
  assign out_event_res      = ev_r;
  assign out_seq_num        = seq_r;
  assign out_packet_payload = pay_r;
  assign out_packet_valid   = pv_r;
  assign out_timer_cmd      = tcmd_r;
  assign out_window_full    = wf_r;
  assign out_last           = last_r;

endmodule

### sv/go_back_n_sender_window.sv
`timescale 1ns / 1ps
// top level of the go-back-n sender window
//
// go-back-n sender. each input word is a send request, an ack or a timer expiry; each result
// word reports what happened, carries a packet to transmit when there is one, and gives the
// command for the external retransmit timer. after a send, an ack, an unused mode or a
// timeout with nothing outstanding, the block takes the next word in the following cycle as
// long as the result register is free or being drained. for a timeout with n packets
// outstanding, the block then does per packet, oldest first, a registered read of the
// payload store and a load of the result register, which waits until that register is free.
// the user must write the window register through cfg_we/cfg_wdata only while the block is
// idle; the block does not enforce it. zero acts as a window of one. the payload store has
// no reset and is only read at outstanding sequence numbers, which have always been written.
module go_back_n_sender_window #(
  parameter int PAYLOAD_BITS = gbn_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [gbn_pkg::WIN_W-1:0] cfg_wdata,
  gbn_in_if.sink                    in_ch,
  gbn_out_if.source                 out_ch
);

  gbn_pkg::gbn_cmd_t cmd;   // controller commands to the datapath
  gbn_pkg::gbn_sts_t sts;   // datapath status back to the controller
  logic              in_ready;

  // controller: handshake and resend sequencing
  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  // datapath: window state, payload store and result register
  gbn_dp #(
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_mode            (in_ch.mode),
    .in_payload         (in_ch.payload),
    .in_ack_num         (in_ch.ack_num),
    .in_ack_checksum_ok (in_ch.ack_checksum_ok),
    .out_ready          (out_ch.ready),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_ch.valid),
    .out_event_res      (out_ch.event_res),
    .out_seq_num        (out_ch.seq_num),
    .out_packet_payload (out_ch.packet_payload),
    .out_packet_valid   (out_ch.packet_valid),
    .out_timer_cmd      (out_ch.timer_cmd),
    .out_window_full    (out_ch.window_full),
    .out_last           (out_ch.last)
  );

  // no new word is taken right after a resend walk starts
  a_walk_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_walk |=> !in_ch.ready)
    else $error("input accepted while resend walk in progress");

  // only a resend walk produces a word that is not the last of its input
  a_multi_only_retx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.last) |-> (out_ch.event_res == gbn_pkg::EV_RETX))
    else $error("non-final result word on a non-resend event");

  // a packet travels only with a send or a resend
  a_packet_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.packet_valid) |->
      (out_ch.event_res == gbn_pkg::EV_SENT || out_ch.event_res == gbn_pkg::EV_RETX))
    else $error("packet carried on a non-packet event");

  // an empty window is never full
  a_empty_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    sts.empty |-> !sts.full)
    else $error("window full with nothing outstanding");

endmodule

### tb/gbn_sender_check.sv
`timescale 1ns / 1ps
// checker for the go-back-n sender: watches both channels, predicts result words and compares
module gbn_sender_check
  import gbn_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [WIN_W-1:0] cfg_wdata,
  gbn_in_if                in_mon,
  gbn_out_if               out_mon,
  output int               fail_count,
  output int               waiting,
  output logic [SEQ_W-1:0] base_seq,
  output logic [SEQ_W-1:0] next_seq
);

  typedef struct packed {
    logic [EV_W-1:0]   ev;
    logic [SEQ_W-1:0]  seq;
    logic [PAY_W-1:0]  pay;
    logic              pv;
    logic [TCMD_W-1:0] tcmd;
    logic              wf;
    logic              last;
  } report_t;

  report_t          due_reports[$];
  logic [WIN_W-1:0] win_q;
  logic [SEQ_W-1:0] base_q;
  logic [SEQ_W-1:0] next_q;
  logic             full_q;
  logic [PAY_W-1:0] sent_payloads[SEQ_SPACE];

  function automatic int in_flight();
    return (int'(next_q) + SEQ_SPACE - int'(base_q)) % SEQ_SPACE;
  endfunction

  // zero acts as one, and the window never covers the whole sequence space
  function automatic int eff_window();
    int w;
    w = int'(win_q);
    if (w == 0) w = 1;
    if (w > SEQ_SPACE - 1) w = SEQ_SPACE - 1;
    return w;
  endfunction

  function automatic void refresh_full();
    full_q = (in_flight() >= eff_window());
  endfunction

  function automatic void add_report(logic [EV_W-1:0] ev, logic [SEQ_W-1:0] seq,
                                     logic [PAY_W-1:0] pay, logic pv,
                                     logic [TCMD_W-1:0] tcmd, logic lst);
    report_t r;
    r.ev   = ev;
    r.seq  = seq;
    r.pay  = pay;
    r.pv   = pv;
    r.tcmd = tcmd;
    r.wf   = full_q;
    r.last = lst;
    due_reports.push_back(r);
  endfunction

  function automatic void predict_word(logic [MODE_W-1:0] mode, logic [PAY_W-1:0] pay,
                                       logic [SEQ_W-1:0] ack, logic ok);
    logic [SEQ_W-1:0]  s;
    logic [TCMD_W-1:0] tc;
    int                n;
    int                ack_gap;
    case (mode)
      MODE_SEND: begin
        refresh_full();
        if (full_q) begin
          add_report(EV_REFUSED, '0, '0, 1'b0, TMR_NONE, 1'b1);
        end else begin
          s = next_q;
          sent_payloads[s] = pay;
          tc = (base_q == next_q) ? TMR_START : TMR_NONE;
          next_q = SEQ_W'((int'(next_q) + 1) % SEQ_SPACE);
          refresh_full();
          add_report(EV_SENT, s, pay, 1'b1, tc, 1'b1);
        end
      end
      MODE_ACK: begin
        ack_gap = (int'(ack) + SEQ_SPACE - int'(base_q)) % SEQ_SPACE;
        if (!ok || ack_gap >= in_flight()) begin
          refresh_full();
          add_report(EV_ACK_IGN, '0, '0, 1'b0, TMR_NONE, 1'b1);
        end else begin
          base_q = SEQ_W'((int'(ack) + 1) % SEQ_SPACE);
          refresh_full();
          add_report(EV_ACK_OK, '0, '0, 1'b0,
                     (base_q == next_q) ? TMR_STOP : TMR_RESTART, 1'b1);
        end
      end
      MODE_TMO: begin
        n = in_flight();
        refresh_full();
        if (n == 0) begin
          add_report(EV_RETX, '0, '0, 1'b0, TMR_RESTART, 1'b1);
        end else begin
          if (n > SEQ_SPACE - 1) n = SEQ_SPACE - 1;
          s = base_q;
          for (int k = 0; k < n; k++) begin
            add_report(EV_RETX, s, sent_payloads[s], 1'b1,
                       (k == 0) ? TMR_RESTART : TMR_NONE, (k + 1 == n));
            s = SEQ_W'((int'(s) + 1) % SEQ_SPACE);
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [PAY_W-1:0] exp_v,
                                      logic [PAY_W-1:0] act_v);
    if (act_v !== exp_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    report_t r;
    if (!rst_n) begin
      win_q      = WIN_RESET;
      base_q     = '0;
      next_q     = '0;
      full_q     = 1'b0;
      fail_count = 0;
      due_reports.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (due_reports.size() == 0) begin
          fail_count++;
          $display("%0t: result word with none expected, expected nothing, actual ev=%0d seq=%0d",
                   $time, out_mon.event_res, out_mon.seq_num);
        end else begin
          r = due_reports.pop_front();
          check_field("event_res", PAY_W'(r.ev), PAY_W'(out_mon.event_res));
          check_field("seq_num", PAY_W'(r.seq), PAY_W'(out_mon.seq_num));
          check_field("packet_payload", r.pay, out_mon.packet_payload);
          check_field("packet_valid", PAY_W'(r.pv), PAY_W'(out_mon.packet_valid));
          check_field("timer_cmd", PAY_W'(r.tcmd), PAY_W'(out_mon.timer_cmd));
          check_field("window_full", PAY_W'(r.wf), PAY_W'(out_mon.window_full));
          check_field("last", PAY_W'(r.last), PAY_W'(out_mon.last));
        end
      end
      // a smaller window can make the sender full at once
      if (cfg_we) begin
        win_q = cfg_wdata;
        refresh_full();
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_word(in_mon.mode, in_mon.payload, in_mon.ack_num, in_mon.ack_checksum_ok);
      end
    end
    waiting  = due_reports.size();
    base_seq = base_q;
    next_seq = next_q;
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// testbench top for the go-back-n sender window: clock, reset, stimulus and verdict
module tb_top;
  import gbn_pkg::*;

  // mode 3 has no meaning in the block and must be dropped without a result
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // worst word: gap, then seven resent packets each behind a stall; far below this
  localparam int LIMIT_CYCLES = 200000;
  // quiet cycles after the last result, covers a word that gives no result
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_WORDS  = 45;
  localparam int PHASES       = 8;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [WIN_W-1:0] cfg_wdata;
  logic             rdy_q = 1'b0;
  bit               idle_on = 1'b1;
  int               stall_left = 0;
  int               cycles = 0;
  int               fail_count;
  int               waiting;
  logic [SEQ_W-1:0] base_seq;
  logic [SEQ_W-1:0] next_seq;

  gbn_in_if  in_ch ();
  gbn_out_if out_ch ();

  assign out_ch.ready = rdy_q;

  go_back_n_sender_window dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  gbn_sender_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .fail_count(fail_count),
    .waiting   (waiting),
    .base_seq  (base_seq),
    .next_seq  (next_seq)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure: random stall bursts while idling is on
  always @(negedge clk) begin
    if (stall_left > 0) begin
      rdy_q <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      rdy_q <= 1'b0;
      stall_left = $urandom_range(0, 5);
    end else begin
      rdy_q <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // present one input word and hold it until it is taken; called and returning at a
  // falling edge, with valid left high so a following word goes out back to back
  task automatic put_word(input logic [MODE_W-1:0] m, input logic [PAY_W-1:0] p,
                          input logic [SEQ_W-1:0] a, input logic ok);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.mode            <= m;
    in_ch.payload         <= p;
    in_ch.ack_num         <= a;
    in_ch.ack_checksum_ok <= ok;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  // window writes only while the block is quiet: no word offered, no result due,
  // and a drain wait for a word that produced nothing
  task automatic set_window(input logic [WIN_W-1:0] v);
    in_ch.valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int               ph;
    int               n_done;
    int               outst;
    int               pick;
    logic [PAY_W-1:0] pay;
    logic [SEQ_W-1:0] ack;
    logic             ok;

    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    in_ch.valid           = 1'b0;
    in_ch.mode            = MODE_SEND;
    in_ch.payload         = '0;
    in_ch.ack_num         = '0;
    in_ch.ack_checksum_ok = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed part, reset window of 4
    put_word(MODE_TMO, '0, '0, 1'b0);             // timeout with nothing outstanding
    put_word(MODE_ACK, '0, 3'd0, 1'b1);           // ack with nothing outstanding
    put_word(MODE_UNUSED, '1, '1, 1'b1);          // unused mode, dropped
    put_word(MODE_SEND, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0);
    put_word(MODE_SEND, 64'h0, '1, 1'b1);
    put_word(MODE_SEND, 64'hA5A5_A5A5_A5A5_A5A5, '0, 1'b0);
    put_word(MODE_SEND, 64'h5A5A_5A5A_5A5A_5A5A, '0, 1'b0);  // window now full
    put_word(MODE_SEND, 64'h1234_5678_9ABC_DEF0, '0, 1'b0);  // refused
    put_word(MODE_TMO, '0, '0, 1'b0);             // resend all four
    put_word(MODE_ACK, '0, 3'd0, 1'b0);           // bad checksum
    put_word(MODE_ACK, '0, 3'd4, 1'b1);           // ack of a packet never sent
    put_word(MODE_ACK, '0, 3'd1, 1'b1);           // cumulative ack, timer restart
    set_window(3'd1);                             // shrink below what is in flight
    put_word(MODE_SEND, '1, '0, 1'b0);            // still refused
    put_word(MODE_ACK, '0, 3'd3, 1'b1);           // all acked, timer stop
    set_window(3'd0);                             // zero acts as one
    put_word(MODE_SEND, 64'h8000_0000_0000_0001, '0, 1'b0);
    put_word(MODE_SEND, '1, '0, 1'b0);
    put_word(MODE_TMO, '0, '0, 1'b0);
    put_word(MODE_ACK, '0, 3'd4, 1'b1);
    set_window(3'd7);                             // widest window, wraps sequence numbers
    repeat (7) put_word(MODE_SEND, {$urandom, $urandom}, '0, 1'b0);
    put_word(MODE_SEND, '1, '0, 1'b0);            // refused at seven in flight
    put_word(MODE_TMO, '0, '0, 1'b0);             // longest resend burst
    put_word(MODE_ACK, '0, 3'd3, 1'b1);

    // random phases, one window setting each; the last runs with no idling
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1) idle_on = 1'b0;
      set_window((ph == 0) ? WIN_W'(7) : (ph == 1) ? WIN_W'(1) :
                 WIN_W'($urandom_range(0, 7)));
      n_done = 0;
      while (n_done < PHASE_WORDS) begin
        outst = (int'(next_seq) + SEQ_SPACE - int'(base_seq)) % SEQ_SPACE;
        pick  = $urandom_range(0, 99);
        pay   = {$urandom, $urandom};
        ack   = SEQ_W'($urandom_range(0, SEQ_SPACE - 1));
        ok    = 1'($urandom_range(0, 1));
        n_done++;
        if (pick < 45) begin
          put_word(MODE_SEND, pay, ack, ok);
        end else if (pick < 75 && outst > 0) begin
          // well-formed ack somewhere inside the outstanding window
          put_word(MODE_ACK, pay,
                   SEQ_W'((int'(base_seq) + $urandom_range(0, outst - 1)) % SEQ_SPACE),
                   1'b1);
        end else if (pick < 85) begin
          put_word(MODE_ACK, pay, ack, ok);
        end else if (pick < 97) begin
          put_word(MODE_TMO, pay, ack, ok);
        end else begin
          put_word(MODE_UNUSED, pay, ack, ok);
          n_done--;
        end
      end
    end

    // drain and verdict
    in_ch.valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
sv/gbn_pkg.sv
sv/gbn_ifs.sv
sv/gbn_ram.sv
sv/gbn_ctrl.sv
sv/gbn_dp.sv
sv/go_back_n_sender_window.sv
tb/gbn_sender_check.sv
tb/tb_top.sv
